// ----- src/direct_form_fir_convolution_macros.svh -----
// Assertion macros shared by the checker of the FIR convolution block.
// No dependencies; included by the files that hold concurrent assertions.
`ifndef DIRECT_FORM_FIR_CONVOLUTION_MACROS_SVH
`define DIRECT_FORM_FIR_CONVOLUTION_MACROS_SVH

// Property checked on every clock edge outside reset.
`define DFFIR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Property that must also hold across reset.
`define DFFIR_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ----- src/dffir_pkg.sv -----
// Shared constants, types and codes of the FIR convolution block.
// No dependencies; imported by every module of the block but dffir_ram.
package dffir_pkg;

   // Sizes of the stores and the arithmetic.
   localparam int MAX_TAPS    = 4096;
   localparam int SAMPLE_BITS = 16;
   localparam int COEF_BITS   = 16;
   localparam int ADDR_BITS   = $clog2(MAX_TAPS);
   localparam int COUNT_BITS  = ADDR_BITS + 1;
   localparam int PROD_BITS   = COEF_BITS + SAMPLE_BITS;
   localparam int SUM_BITS    = 44;

   // Field widths of the stream items and the tap count register.
   localparam int OP_BITS    = 2;
   localparam int INDEX_BITS = 12;
   localparam int TAPS_BITS  = 13;

   // Packing of the request tdata: tap_index, tap_value, sample from bit 0 up.
   localparam int IDX_LSB        = 0;
   localparam int TAPV_LSB       = IDX_LSB + INDEX_BITS;
   localparam int SAMP_LSB       = TAPV_LSB + COEF_BITS;
   localparam int REQ_FIELD_BITS = SAMP_LSB + SAMPLE_BITS;
   localparam int REQ_TDATA_BITS = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_BITS = ((SUM_BITS + 7) / 8) * 8;

   // Request kinds carried in req_tuser; the fourth code is ignored.
   typedef enum logic [OP_BITS-1:0] {
      OP_LOAD_TAP = 2'd0,
      OP_PUSH     = 2'd1,
      OP_CLEAR    = 2'd2
   } opcode_type;

   // Sequencer states, one-hot.
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_RUN    = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   // One tap step handed from the sequencer to the multiply-accumulate pipe.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
      logic live;
   } tap_cmd_type;

endpackage

// ----- src/dffir_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies; instanced for the coefficient store and the sample history.
module dffir_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/dffir_mac.sv -----
// Multiply-accumulate pipe: aligns tap steps with RAM data, multiplies, sums.
// Depends on dffir_pkg for widths and the tap step struct.
module dffir_mac
   import dffir_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  tap_cmd_type                   cmd,
   input  logic signed [COEF_BITS-1:0]   coef,
   input  logic signed [SAMPLE_BITS-1:0] samp,
   output logic                          done,
   output logic signed [SUM_BITS-1:0]    sum
);

   tap_cmd_type                  cmd_s1_ff, cmd_s2_ff;
   logic signed [PROD_BITS-1:0]  coef_ext, samp_ext;
   logic signed [PROD_BITS-1:0]  prod_in, prod_ff;
   logic signed [SUM_BITS-1:0]   acc_in, acc_ff;
   logic                         done_in, done_ff;

   // Product of the words that the RAMs return; a step outside the filled
   // history contributes zero.
   always_comb begin
      coef_ext = PROD_BITS'(coef);
      samp_ext = PROD_BITS'(samp);
      prod_in  = cmd_s1_ff.live ? PROD_BITS'(coef_ext * samp_ext) : '0;
   end

   // Accumulator restarts on the first step of each push.
   always_comb begin
      acc_in  = cmd_s2_ff.first ? SUM_BITS'(prod_ff) : acc_ff + SUM_BITS'(prod_ff);
      done_in = cmd_s2_ff.valid && cmd_s2_ff.last;
   end

   // Step control travels alongside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_s1_ff <= '0;
         cmd_s2_ff <= '0;
         done_ff   <= 1'b0;
      end else begin
         cmd_s1_ff <= cmd;
         cmd_s2_ff <= cmd_s1_ff;
         done_ff   <= done_in;
      end
   end

   // Data registers; the sum holds until the next push starts.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd_s2_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   assign done = done_ff;
   assign sum  = acc_ff;

endmodule

// ----- src/dffir_ctrl.sv -----
// Sequencer: takes requests, keeps the history pointer and fill count, walks
// the taps through the RAMs and holds the result register. Uses dffir_pkg.
module dffir_ctrl
   import dffir_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // Request side.
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [OP_BITS-1:0]         opcode,
   input  logic [INDEX_BITS-1:0]      tap_index,
   input  logic [COEF_BITS-1:0]       tap_value,
   input  logic [SAMPLE_BITS-1:0]     sample,
   // Tap count register.
   input  logic                       csr_wen,
   input  logic [TAPS_BITS-1:0]       csr_wdata,
   // Coefficient store.
   output logic                       coef_wr_en,
   output logic [ADDR_BITS-1:0]       coef_wr_addr,
   output logic [COEF_BITS-1:0]       coef_wr_data,
   output logic [ADDR_BITS-1:0]       coef_rd_addr,
   // Sample history.
   output logic                       hist_wr_en,
   output logic [ADDR_BITS-1:0]       hist_wr_addr,
   output logic [SAMPLE_BITS-1:0]     hist_wr_data,
   output logic [ADDR_BITS-1:0]       hist_rd_addr,
   // Multiply-accumulate pipe.
   output tap_cmd_type                cmd,
   input  logic                       mac_done,
   input  logic signed [SUM_BITS-1:0] mac_sum,
   // Result side.
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [SUM_BITS-1:0]        rsp_sum
);

   state_type               state_ff, state_in;
   logic [TAPS_BITS-1:0]    num_taps_ff, num_taps_in;
   logic [ADDR_BITS-1:0]    head_ff, head_in;
   logic [ADDR_BITS-1:0]    newest_ff, newest_in;
   logic [COUNT_BITS-1:0]   fill_ff, fill_in;
   logic [ADDR_BITS-1:0]    step_ff, step_in;
   logic [ADDR_BITS-1:0]    last_step_ff, last_step_in;
   logic                    any_taps_ff, any_taps_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SUM_BITS-1:0]     rsp_sum_ff, rsp_sum_in;
   logic                    accept;
   logic [COUNT_BITS-1:0]   taps_eff;
   logic [COUNT_BITS-1:0]   back_diff;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Steps per push: the tap count clamped to the store, at least one.
   always_comb begin
      if (num_taps_ff == '0) begin
         taps_eff = COUNT_BITS'(1);
      end else if (32'(num_taps_ff) >= MAX_TAPS) begin
         taps_eff = COUNT_BITS'(MAX_TAPS);
      end else begin
         taps_eff = COUNT_BITS'(num_taps_ff);
      end
   end

   // Coefficient loads go straight to the store.
   always_comb begin
      coef_wr_en   = accept && (opcode == OP_LOAD_TAP) && (32'(tap_index) < MAX_TAPS);
      coef_wr_addr = ADDR_BITS'(tap_index);
      coef_wr_data = tap_value;
   end

   // A push writes its sample into the slot at the head pointer.
   always_comb begin
      hist_wr_en   = accept && (opcode == OP_PUSH);
      hist_wr_addr = head_ff;
      hist_wr_data = sample;
   end

   // Read addresses: tap j pairs with the sample j places back, wrapping.
   always_comb begin
      back_diff    = COUNT_BITS'(newest_ff) - COUNT_BITS'(step_ff);
      if (back_diff[COUNT_BITS-1]) begin
         back_diff = back_diff + COUNT_BITS'(MAX_TAPS);
      end
      hist_rd_addr = ADDR_BITS'(back_diff);
      coef_rd_addr = step_ff;
   end

   // One tap step per cycle while running; only filled history counts.
   always_comb begin
      cmd.valid = (state_ff == ST_RUN);
      cmd.first = (step_ff == '0);
      cmd.last  = (step_ff == last_step_ff);
      cmd.live  = any_taps_ff && (COUNT_BITS'(step_ff) < fill_ff);
   end

   // Sequencer and state updates.
   always_comb begin
      state_in     = state_ff;
      num_taps_in  = csr_wen ? csr_wdata : num_taps_ff;
      head_in      = head_ff;
      newest_in    = newest_ff;
      fill_in      = fill_ff;
      step_in      = step_ff;
      last_step_in = last_step_ff;
      any_taps_in  = any_taps_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_sum_in   = rsp_sum_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (opcode)
                  OP_PUSH: begin
                     newest_in    = head_ff;
                     head_in      = (32'(head_ff) == MAX_TAPS - 1) ? '0
                                    : head_ff + ADDR_BITS'(1);
                     fill_in      = (32'(fill_ff) == MAX_TAPS) ? fill_ff
                                    : fill_ff + COUNT_BITS'(1);
                     step_in      = '0;
                     last_step_in = ADDR_BITS'(taps_eff - COUNT_BITS'(1));
                     any_taps_in  = (num_taps_ff != '0);
                     state_in     = ST_RUN;
                  end
                  OP_CLEAR: begin
                     head_in = '0;
                     fill_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RUN: begin
            step_in = step_ff + ADDR_BITS'(1);
            if (step_ff == last_step_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (mac_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = mac_sum;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         num_taps_ff  <= TAPS_BITS'(1);
         head_ff      <= '0;
         fill_ff      <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         num_taps_ff  <= num_taps_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      newest_ff    <= newest_in;
      last_step_ff <= last_step_in;
      any_taps_ff  <= any_taps_in;
      rsp_sum_ff   <= rsp_sum_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_sum    = rsp_sum_ff;

endmodule

// ----- src/direct_form_fir_convolution.sv -----
// Top level of the direct-form FIR convolution block.
// Depends on dffir_pkg, dffir_ram, dffir_ctrl and dffir_mac.
//
// Usage:
//   req channel: one transfer per request. req_tuser selects the kind: load
//   one coefficient, push one sample, or clear the sample history. A push
//   gives exactly one transfer on the rsp channel carrying the exact sum of
//   products over the taps in use; loads, clears and the unused code give none.
//   csr port: writes the number of taps in use (reset value 1). Write it only
//   while no push is in flight.
//   A load or clear leaves the block ready for the next request. A push
//   walks the coefficient store and the sample history, one multiply-accumulate
//   per cycle through a single read port on each RAM, over
//   N = min(max(num_taps, 1), 4096) taps, then hands the sum to the output.
//   The next request is taken once the result sits in the output register.
//   Reset clears the history pointer and fill count (the history reads as
//   zero at once, no clearing pass), sets the tap count to 1 and empties the
//   output register; coefficients are undefined until loaded.
//   If the receiver stalls, the result waits in the output register; one
//   more push may run, then it waits for the register to empty.
module direct_form_fir_convolution
   import dffir_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // Request stream.
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // tap_index [11:0], tap_value [27:12], sample [43:28], zero [47:44]
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   // opcode [1:0]
   input  logic [OP_BITS-1:0]        req_tuser,
   // Result stream.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // filtered_sum [43:0], zero [47:44]
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   // Tap count register.
   input  logic                      csr_wen,
   input  logic [TAPS_BITS-1:0]      csr_wdata
);

   logic                       coef_wr_en, hist_wr_en;
   logic [ADDR_BITS-1:0]       coef_wr_addr, coef_rd_addr, hist_wr_addr, hist_rd_addr;
   logic [COEF_BITS-1:0]       coef_wr_data, coef_rd_data;
   logic [SAMPLE_BITS-1:0]     hist_wr_data, hist_rd_data;
   tap_cmd_type                cmd;
   logic                       mac_done;
   logic signed [SUM_BITS-1:0] mac_sum;
   logic [SUM_BITS-1:0]        rsp_sum;

   // Sequencer.
   dffir_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .opcode       (req_tuser),
      .tap_index    (req_tdata[TAPV_LSB-1:IDX_LSB]),
      .tap_value    (req_tdata[SAMP_LSB-1:TAPV_LSB]),
      .sample       (req_tdata[REQ_FIELD_BITS-1:SAMP_LSB]),
      .csr_wen      (csr_wen),
      .csr_wdata    (csr_wdata),
      .coef_wr_en   (coef_wr_en),
      .coef_wr_addr (coef_wr_addr),
      .coef_wr_data (coef_wr_data),
      .coef_rd_addr (coef_rd_addr),
      .hist_wr_en   (hist_wr_en),
      .hist_wr_addr (hist_wr_addr),
      .hist_wr_data (hist_wr_data),
      .hist_rd_addr (hist_rd_addr),
      .cmd          (cmd),
      .mac_done     (mac_done),
      .mac_sum      (mac_sum),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_sum      (rsp_sum)
   );

   // Coefficient store.
   dffir_ram #(
      .WIDTH (COEF_BITS),
      .DEPTH (MAX_TAPS)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_wr_en),
      .wr_addr (coef_wr_addr),
      .wr_data (coef_wr_data),
      .rd_addr (coef_rd_addr),
      .rd_data (coef_rd_data)
   );

   // Circular sample history.
   dffir_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_TAPS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (hist_wr_addr),
      .wr_data (hist_wr_data),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data)
   );

   // Multiply-accumulate pipe.
   dffir_mac u_mac (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .coef  (coef_rd_data),
      .samp  (hist_rd_data),
      .done  (mac_done),
      .sum   (mac_sum)
   );

   // Result payload, padded with zeros to whole bytes.
   assign rsp_tdata = RSP_TDATA_BITS'(rsp_sum);

endmodule

// ----- src/dffir_checker.sv -----
// Port-level checker for the FIR convolution block, bound to the top level.
// Depends on dffir_pkg and direct_form_fir_convolution_macros.svh.
`include "direct_form_fir_convolution_macros.svh"

module dffir_checker
   import dffir_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [OP_BITS-1:0]        req_tuser,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_TDATA_BITS-1:0] rsp_tdata
);

   logic push_xfer, quick_xfer;

   assign push_xfer  = req_tvalid && req_tready && (req_tuser == OP_PUSH);
   assign quick_xfer = req_tvalid && req_tready && (req_tuser != OP_PUSH);

   // A stalled result holds its value.
   `DFFIR_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))

   // Nothing is offered on the result side right after reset.
   `DFFIR_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_tvalid)

   // A push keeps the block busy for at least the next cycle.
   `DFFIR_ASSERT(a_push_busy, clock, reset, push_xfer |=> !req_tready)

   // Loads, clears and the unused code leave the block ready in the next cycle.
   `DFFIR_ASSERT(a_quick_ready, clock, reset, quick_xfer |=> req_tready)

   // The pad bits of the result are zero.
   `DFFIR_ASSERT(a_rsp_pad, clock, reset, rsp_tvalid |-> rsp_tdata[RSP_TDATA_BITS-1:SUM_BITS] == '0)

endmodule

bind direct_form_fir_convolution dffir_checker u_dffir_checker (.*);

// ----- dv/testbench.sv -----
// Self-checking testbench of the direct-form FIR convolution block.
// Depends on dffir_pkg and direct_form_fir_convolution; a clocked driver and
// monitor run against an in-bench convolution predictor.
module testbench;
   import dffir_pkg::*;

   // Code of the request kind that the block ignores.
   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
   localparam int IDLE_MAX = 18;
   localparam int LONG_HOLD = 300;

   typedef struct {
      logic [OP_BITS-1:0]            opcode;
      logic [INDEX_BITS-1:0]         tap_index;
      logic signed [COEF_BITS-1:0]   tap_value;
      logic signed [SAMPLE_BITS-1:0] sample;
      bit                            drain_first;
   } fir_request;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic [OP_BITS-1:0]        req_tuser = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      csr_wen = 1'b0;
   logic [TAPS_BITS-1:0]      csr_wdata = '0;

   // Predictor state: coefficients, circular sample history, tap count.
   logic signed [COEF_BITS-1:0]   coef_model [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] history_model [MAX_TAPS];
   logic [ADDR_BITS-1:0]          history_head = '0;
   int unsigned                   taps_in_use = 1;

   // Requests waiting to be sent and sums waiting to come back.
   fir_request                  pending_requests[$];
   logic signed [SUM_BITS-1:0]  sums_due[$];
   bit                          tap_written [MAX_TAPS];
   int unsigned                 requests_queued = 0;
   int unsigned                 requests_accepted = 0;
   int unsigned                 failures = 0;
   int unsigned                 hold_requests = 0;

   direct_form_fir_convolution uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one accepted request to the predictor; a push yields the
   // expected exact sum of products over the taps in use.
   function automatic void apply_request(fir_request r);
      logic signed [63:0]   acc;
      logic [ADDR_BITS-1:0] pos;
      int unsigned          used;
      int unsigned          j;
      case (r.opcode)
         OP_LOAD_TAP: coef_model[r.tap_index] = r.tap_value;
         OP_CLEAR: begin
            history_model = '{default: '0};
            history_head = '0;
         end
         OP_PUSH: begin
            used = (taps_in_use > MAX_TAPS) ? MAX_TAPS : taps_in_use;
            history_model[history_head] = r.sample;
            acc = '0;
            for (j = 0; j < used; j++) begin
               pos = history_head - j[ADDR_BITS-1:0];
               acc = acc + coef_model[j] * history_model[pos];
            end
            history_head = history_head + 1'b1;
            sums_due.insert(sums_due.size(), acc[SUM_BITS-1:0]);
         end
         default: ;
      endcase
   endfunction

   function automatic void queue_request(logic [OP_BITS-1:0] op,
                                         logic [INDEX_BITS-1:0] idx,
                                         logic signed [COEF_BITS-1:0] val,
                                         logic signed [SAMPLE_BITS-1:0] smp,
                                         bit drain);
      fir_request r;
      r.opcode = op;
      r.tap_index = idx;
      r.tap_value = val;
      r.sample = smp;
      r.drain_first = drain;
      pending_requests.insert(pending_requests.size(), r);
      requests_queued++;
      if (op == OP_LOAD_TAP)
         tap_written[idx] = 1'b1;
   endfunction

   // Random coefficient position and random 16-bit word for unused fields.
   function automatic logic [INDEX_BITS-1:0] rand_index();
      return INDEX_BITS'($urandom);
   endfunction

   function automatic logic [15:0] rand_word();
      return 16'($urandom);
   endfunction

   // Full-range value with the two extremes drawn more often.
   function automatic logic signed [15:0] random_q15();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0)
         return 16'sh7fff;
      else if (roll == 1)
         return 16'sh8000;
      return 16'($urandom);
   endfunction

   // Loads every coefficient below n that was never written.
   function automatic void load_missing_taps(int unsigned n);
      int unsigned i;
      for (i = 0; i < n && i < MAX_TAPS; i++) begin
         if (!tap_written[i])
            queue_request(OP_LOAD_TAP, INDEX_BITS'(i), random_q15(), rand_word(), 1'b0);
      end
   endfunction

   // Mostly pushes, with loads, clears, ignored codes and drain points mixed in.
   function automatic void queue_random_request();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 62)
         queue_request(OP_PUSH, rand_index(), rand_word(), random_q15(), 1'b0);
      else if (roll < 82)
         queue_request(OP_LOAD_TAP, rand_index(), random_q15(), rand_word(), 1'b0);
      else if (roll < 88)
         queue_request(OP_CLEAR, rand_index(), rand_word(), rand_word(), 1'b0);
      else if (roll < 93)
         queue_request(OP_UNUSED, rand_index(), rand_word(), rand_word(), 1'b0);
      else
         queue_request(OP_PUSH, rand_index(), rand_word(), random_q15(), 1'b1);
   endfunction

   // Waits until every queued request was taken and every sum came back,
   // then lets a load or clear still inside the block finish.
   task automatic wait_quiet();
      while (requests_accepted != requests_queued || sums_due.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic set_tap_count(int unsigned n);
      wait_quiet();
      csr_wen <= 1'b1;
      csr_wdata <= n[TAPS_BITS-1:0];
      taps_in_use = n;
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   // Sender: takes requests from the queue, idles a random number of cycles
   // between transfers, and holds a drain point until all sums are back.
   fir_request                in_flight;
   logic                      offering;
   logic [REQ_TDATA_BITS-1:0] next_tdata;
   int unsigned               send_gap = 0;
   int unsigned               send_calm = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= '0;
         send_gap = 0;
         send_calm = 0;
      end else begin
         offering = req_tvalid;
         if (req_tvalid && req_tready) begin
            apply_request(in_flight);
            requests_accepted++;
            offering = 1'b0;
            if (send_calm > 0) begin
               send_calm--;
               send_gap = 0;
            end else begin
               if ($urandom_range(0, 11) == 0)
                  send_calm = $urandom_range(4, 16);
               send_gap = $urandom_range(0, IDLE_MAX);
            end
         end
         if (!offering) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_requests.size() > 0 &&
                         !(pending_requests[0].drain_first && sums_due.size() > 0)) begin
               in_flight = pending_requests.pop_front();
               offering = 1'b1;
               next_tdata = '0;
               next_tdata[IDX_LSB +: INDEX_BITS] = in_flight.tap_index;
               next_tdata[TAPV_LSB +: COEF_BITS] = in_flight.tap_value;
               next_tdata[SAMP_LSB +: SAMPLE_BITS] = in_flight.sample;
               req_tdata <= next_tdata;
               req_tuser <= in_flight.opcode;
            end
         end
         req_tvalid <= offering;
      end
   end

   // Receiver: checks each result transfer against the oldest expected sum,
   // stalls at random after each one, and honors long hold-off requests.
   logic signed [SUM_BITS-1:0] got_sum;
   logic signed [SUM_BITS-1:0] want_sum;
   int unsigned                recv_stall = 0;
   int unsigned                recv_calm = 0;
   int unsigned                hold_left = 0;
   int unsigned                holds_served = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall = 0;
         recv_calm = 0;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_sum = rsp_tdata[SUM_BITS-1:0];
            if (sums_due.size() == 0) begin
               failures++;
               $error("filtered_sum: no result expected, actual %0d", got_sum);
            end else begin
               want_sum = sums_due.pop_front();
               if (got_sum !== want_sum) begin
                  failures++;
                  $error("filtered_sum: expected %0d, actual %0d", want_sum, got_sum);
               end
            end
            if (recv_calm > 0) begin
               recv_calm--;
               recv_stall = 0;
            end else begin
               if ($urandom_range(0, 11) == 0)
                  recv_calm = $urandom_range(4, 16);
               recv_stall = $urandom_range(0, IDLE_MAX);
            end
         end
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Stimulus: directed corner cases, random phases at several tap counts,
   // and back-pressure with a drain point.
   int unsigned tap_settings [5] = '{2, 7, 1, 16, 24};
   int unsigned phase;
   int unsigned k;

   initial begin
      history_model = '{default: '0};
      coef_model = '{default: '0};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Largest products of either sign with a single tap, ignored code, clear.
      queue_request(OP_LOAD_TAP, 12'd0, 16'sh7fff, rand_word(), 1'b0);
      queue_request(OP_PUSH, rand_index(), rand_word(), 16'sh7fff, 1'b0);
      queue_request(OP_PUSH, rand_index(), rand_word(), 16'sh8000, 1'b0);
      queue_request(OP_UNUSED, rand_index(), rand_word(), rand_word(), 1'b0);
      queue_request(OP_LOAD_TAP, 12'd0, 16'sh8000, rand_word(), 1'b0);
      queue_request(OP_PUSH, rand_index(), rand_word(), 16'sh8000, 1'b0);
      queue_request(OP_LOAD_TAP, 12'hfff, random_q15(), rand_word(), 1'b0);
      queue_request(OP_CLEAR, rand_index(), rand_word(), rand_word(), 1'b0);
      queue_request(OP_PUSH, rand_index(), rand_word(), 16'sd1, 1'b0);

      // No taps in use: the sum is zero but the sample still enters.
      set_tap_count(0);
      queue_request(OP_PUSH, rand_index(), rand_word(), 16'sd12345, 1'b0);
      queue_request(OP_PUSH, rand_index(), rand_word(), 16'sh8000, 1'b0);

      set_tap_count(3);
      queue_request(OP_LOAD_TAP, 12'd1, 16'sh7fff, rand_word(), 1'b0);
      queue_request(OP_LOAD_TAP, 12'd2, -16'sd1, rand_word(), 1'b0);
      queue_request(OP_PUSH, rand_index(), rand_word(), 16'sd100, 1'b0);
      queue_request(OP_PUSH, rand_index(), rand_word(), 16'sh8000, 1'b0);
      queue_request(OP_PUSH, rand_index(), rand_word(), 16'sh7fff, 1'b0);
      queue_request(OP_CLEAR, rand_index(), rand_word(), rand_word(), 1'b0);
      queue_request(OP_PUSH, rand_index(), rand_word(), 16'sd5, 1'b0);
      queue_request(OP_UNUSED, rand_index(), rand_word(), rand_word(), 1'b0);

      // Random traffic over a handful of small tap counts.
      for (phase = 0; phase < 5; phase++) begin
         set_tap_count(tap_settings[phase]);
         load_missing_taps(tap_settings[phase]);
         for (k = 0; k < 14; k++)
            queue_random_request();
      end

      // Receiver holds off while pushes keep coming, so the block stalls its
      // input; then the sender waits for every sum before going on.
      set_tap_count(8);
      load_missing_taps(8);
      hold_requests++;
      for (k = 0; k < 10; k++)
         queue_request(OP_PUSH, rand_index(), rand_word(), random_q15(), 1'b0);
      queue_request(OP_PUSH, rand_index(), rand_word(), random_q15(), 1'b1);
      for (k = 0; k < 4; k++)
         queue_random_request();

      set_tap_count(6);
      for (k = 0; k < 8; k++)
         queue_random_request();

      wait_quiet();
      repeat (40) @(posedge clock);
      if (failures == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+src
src/dffir_pkg.sv
src/dffir_ram.sv
src/dffir_mac.sv
src/dffir_ctrl.sv
src/direct_form_fir_convolution.sv
src/dffir_checker.sv
dv/testbench.sv
